### hw/rtl/cba_pkg.sv
// Shared types and constants for the cable block allocator.
// Holds the request, response and slot-table entry layouts and the operation,
// status and controller state codes. Depends on nothing.
package cba_pkg;

    localparam int SLOTS_DEF  = 4;
    localparam int CABLES_DEF = 16;
    localparam int OWNER_W    = 3;
    localparam int COUNT_W    = 5;

    localparam logic [OWNER_W-1:0] UNOWNED   = 3'd7;
    localparam logic [4:0]         HOST_BASE = 5'd16;

    typedef enum logic [1:0] {
        OP_MOUNT   = 2'd0,
        OP_UNMOUNT = 2'd1,
        OP_SEND    = 2'd2,
        OP_RECEIVE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_UNAVAIL = 2'd1,
        STAT_NO_SLOT = 2'd2,
        STAT_NO_ROOM = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FIT_SCAN,
        S_FIT_WRITE,
        S_SLOT_SCAN,
        S_FREE,
        S_SEND_OWN,
        S_SEND_SLOT,
        S_EMIT
    } ctrl_state_t;

    typedef struct packed {
        op_t        operation;
        logic [4:0] port_index;
        logic [7:0] interface_id;
        logic [4:0] rx_cables;
        logic [4:0] tx_cables;
        logic       from_device_side;
        logic [3:0] packet_cable;
        logic       device_mounted;
        logic       interface_mounted;
    } req_t;

    typedef struct packed {
        status_t    status;
        logic [4:0] global_index;
        logic       target_host_side;
        logic [7:0] target_interface;
        logic [3:0] local_cable;
        logic [1:0] slot_used;
        logic [3:0] block_start;
        logic [4:0] block_size;
    } rsp_t;

    typedef struct packed {
        logic [7:0]         iface;
        logic [3:0]         first;
        logic [COUNT_W-1:0] count;
    } slot_entry_t;

endpackage

### hw/rtl/cba_req_if.sv
// Request channel of the cable block allocator: valid, ready and request payload.
// Depends on cba_pkg for the request layout.
interface cba_req_if;
    import cba_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/cba_rsp_if.sv
// Response channel of the cable block allocator: valid, ready and response payload.
// Depends on cba_pkg for the response layout.
interface cba_rsp_if;
    import cba_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/cba_owner_mem.sv
// Cable ownership map: one synchronous memory, one write and one read port.
// Per-entry valid bits make unwritten entries read as unowned. Depends on cba_pkg.
module cba_owner_mem #(
    parameter int  CABLES = cba_pkg::CABLES_DEF,
    localparam int CW     = (CABLES > 1) ? $clog2(CABLES) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [CW-1:0]                wr_addr,
    input  logic [cba_pkg::OWNER_W-1:0]  wr_data,
    input  logic [CW-1:0]                rd_addr,
    output logic [cba_pkg::OWNER_W-1:0]  rd_data
);
    import cba_pkg::*;

    logic [OWNER_W-1:0] owner_mem [CABLES];
    logic [OWNER_W-1:0] rd_data_reg;
    logic [CABLES-1:0]  valid_reg;
    logic               rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            owner_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= owner_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : UNOWNED;

endmodule

### hw/rtl/cba_slot_mem.sv
// Slot table: interface id, first cable and cable count per slot.
// One synchronous memory with registered read. Depends on cba_pkg.
module cba_slot_mem #(
    parameter int  SLOTS = cba_pkg::SLOTS_DEF,
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [SW-1:0]         wr_addr,
    input  cba_pkg::slot_entry_t  wr_data,
    input  logic [SW-1:0]         rd_addr,
    output cba_pkg::slot_entry_t  rd_data
);
    import cba_pkg::*;

    slot_entry_t slot_mem [SLOTS];
    slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/cba_ctrl.sv
// Sequencer of the cable block allocator: decodes a request, scans the ownership
// map and slot table through their read ports and writes back grants and releases.
// Depends on cba_pkg; drives cba_owner_mem and cba_slot_mem.
module cba_ctrl #(
    parameter int  SLOTS  = cba_pkg::SLOTS_DEF,
    parameter int  CABLES = cba_pkg::CABLES_DEF,
    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CW     = (CABLES > 1) ? $clog2(CABLES) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  cba_pkg::req_t                req_payload,
    output logic                         res_valid,
    input  logic                         res_ready,
    output cba_pkg::rsp_t                res,
    input  logic                         cfg_wr_en,
    input  logic [4:0]                   cfg_wr_data,
    output logic                         owner_wr_en,
    output logic [CW-1:0]                owner_wr_addr,
    output logic [cba_pkg::OWNER_W-1:0]  owner_wr_data,
    output logic [CW-1:0]                owner_rd_addr,
    input  logic [cba_pkg::OWNER_W-1:0]  owner_rd_data,
    output logic                         slot_wr_en,
    output logic [SW-1:0]                slot_wr_addr,
    output cba_pkg::slot_entry_t         slot_wr_data,
    output logic [SW-1:0]                slot_rd_addr,
    input  cba_pkg::slot_entry_t         slot_rd_data
);
    import cba_pkg::*;

    ctrl_state_t        state_reg, state_next;
    req_t               req_reg, req_next;
    rsp_t               res_reg, res_next;
    logic [SLOTS-1:0]   busy_reg, busy_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      run_start_reg, run_start_next;
    logic [COUNT_W-1:0] run_len_reg, run_len_next;
    logic [COUNT_W-1:0] num_reg, num_next;
    logic [SW-1:0]      scan_reg, scan_next;
    logic [4:0]         dev_ports_reg;

    logic [COUNT_W-1:0] max_cables;
    logic [COUNT_W-1:0] num_calc;
    logic               free_found;
    logic [SW-1:0]      free_slot;
    logic               own_free;
    logic [COUNT_W-1:0] run_len_inc;
    logic               fit;
    logic [CW-1:0]      fit_start;
    logic               cnt_last;
    logic               scan_last;
    logic               slot_match;
    logic [3:0]         send_cable;
    logic               send_host;
    logic               cable_ok;
    logic               dev_send_ok;
    logic               own_ok;
    logic [4:0]         rx_sum;
    logic               rx_sum_ok;

    assign max_cables  = (req_reg.rx_cables > req_reg.tx_cables) ? req_reg.rx_cables
                                                                 : req_reg.tx_cables;
    assign num_calc    = (max_cables == '0) ? COUNT_W'(1) : max_cables;
    assign own_free    = owner_rd_data == UNOWNED;
    assign run_len_inc = run_len_reg + COUNT_W'(1);
    assign fit         = own_free && (run_len_inc == num_reg);
    assign fit_start   = (run_len_reg == '0) ? cnt_reg : run_start_reg;
    assign cnt_last    = cnt_reg == CW'(CABLES - 1);
    assign scan_last   = scan_reg == SW'(SLOTS - 1);
    assign slot_match  = busy_reg[scan_reg] && (slot_rd_data.iface == req_reg.interface_id);
    assign send_cable  = req_reg.port_index[3:0];
    assign send_host   = req_reg.port_index[4];
    assign cable_ok    = {1'b0, send_cable} < 5'(CABLES);
    assign dev_send_ok = ({1'b0, send_cable} < dev_ports_reg) && req_reg.device_mounted;
    assign own_ok      = (owner_rd_data < OWNER_W'(SLOTS))
                         && busy_reg[owner_rd_data[SW-1:0]]
                         && req_reg.interface_mounted;
    assign rx_sum      = {1'b0, slot_rd_data.first} + {1'b0, req_reg.packet_cable};
    assign rx_sum_ok   = rx_sum < 5'(CABLES);

    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (!busy_reg[s])
            begin
                free_found = 1'b1;
                free_slot  = SW'(s);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= '0;
            dev_ports_reg <= 5'd1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            if (cfg_wr_en)
            begin
                dev_ports_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        res_reg       <= res_next;
        cnt_reg       <= cnt_next;
        run_start_reg <= run_start_next;
        run_len_reg   <= run_len_next;
        num_reg       <= num_next;
        scan_reg      <= scan_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (req_reg.operation)
                    OP_MOUNT:
                    begin
                        if (!free_found || num_calc > COUNT_W'(CABLES))
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_FIT_SCAN;
                        end
                    end
                    OP_UNMOUNT:
                    begin
                        state_next = S_SLOT_SCAN;
                    end
                    OP_SEND:
                    begin
                        state_next = (send_host && cable_ok) ? S_SEND_OWN : S_EMIT;
                    end
                    default:
                    begin
                        state_next = req_reg.from_device_side ? S_EMIT : S_SLOT_SCAN;
                    end
                endcase
            end
            S_FIT_SCAN:
            begin
                if (fit)
                begin
                    state_next = S_FIT_WRITE;
                end
                else if (cnt_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_FIT_WRITE:
            begin
                if (run_len_reg <= COUNT_W'(1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_SLOT_SCAN:
            begin
                if (slot_match)
                begin
                    state_next = (req_reg.operation == OP_UNMOUNT) ? S_FREE : S_EMIT;
                end
                else if (scan_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_FREE:
            begin
                if (run_len_reg <= COUNT_W'(1) || cnt_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_SEND_OWN:
            begin
                state_next = own_ok ? S_SEND_SLOT : S_EMIT;
            end
            S_SEND_SLOT:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        req_next       = req_reg;
        res_next       = res_reg;
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        run_start_next = run_start_reg;
        run_len_next   = run_len_reg;
        num_next       = num_reg;
        scan_next      = scan_reg;

        owner_wr_en        = 1'b0;
        owner_wr_addr      = cnt_reg;
        owner_wr_data      = UNOWNED;
        owner_rd_addr      = '0;
        slot_wr_en         = 1'b0;
        slot_wr_addr       = scan_reg;
        slot_wr_data.iface = req_reg.interface_id;
        slot_wr_data.first = 4'(fit_start);
        slot_wr_data.count = num_reg;
        slot_rd_addr       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req_payload;
                    res_next = '0;
                end
            end
            S_DECODE:
            begin
                case (req_reg.operation)
                    OP_MOUNT:
                    begin
                        num_next     = num_calc;
                        scan_next    = free_slot;
                        cnt_next     = '0;
                        run_len_next = '0;
                        if (!free_found)
                        begin
                            res_next.status = STAT_NO_SLOT;
                        end
                        else if (num_calc > COUNT_W'(CABLES))
                        begin
                            res_next.status = STAT_NO_ROOM;
                        end
                    end
                    OP_UNMOUNT:
                    begin
                        scan_next = '0;
                    end
                    OP_SEND:
                    begin
                        if (!send_host)
                        begin
                            if (dev_send_ok)
                            begin
                                res_next.local_cable = send_cable;
                            end
                            else
                            begin
                                res_next.status = STAT_UNAVAIL;
                            end
                        end
                        else if (!cable_ok)
                        begin
                            res_next.status = STAT_UNAVAIL;
                        end
                        else
                        begin
                            owner_rd_addr = CW'(send_cable);
                        end
                    end
                    default:
                    begin
                        scan_next = '0;
                        if (req_reg.from_device_side)
                        begin
                            if (req_reg.device_mounted)
                            begin
                                res_next.global_index = {1'b0, req_reg.packet_cable};
                            end
                            else
                            begin
                                res_next.status = STAT_UNAVAIL;
                            end
                        end
                    end
                endcase
            end
            S_FIT_SCAN:
            begin
                owner_rd_addr = cnt_reg + CW'(1);
                cnt_next      = cnt_reg + CW'(1);
                if (fit)
                begin
                    cnt_next                = fit_start;
                    run_start_next          = fit_start;
                    run_len_next            = num_reg;
                    slot_wr_en              = 1'b1;
                    busy_next[scan_reg]     = 1'b1;
                    res_next.slot_used      = 2'(scan_reg);
                    res_next.block_start    = 4'(fit_start);
                    res_next.block_size     = num_reg;
                end
                else if (own_free)
                begin
                    run_len_next   = run_len_inc;
                    run_start_next = fit_start;
                    if (cnt_last)
                    begin
                        res_next.status = STAT_NO_ROOM;
                    end
                end
                else
                begin
                    run_len_next = '0;
                    if (cnt_last)
                    begin
                        res_next.status = STAT_NO_ROOM;
                    end
                end
            end
            S_FIT_WRITE:
            begin
                owner_wr_en   = 1'b1;
                owner_wr_data = OWNER_W'(scan_reg);
                cnt_next      = cnt_reg + CW'(1);
                run_len_next  = run_len_reg - COUNT_W'(1);
            end
            S_SLOT_SCAN:
            begin
                slot_rd_addr = scan_reg + SW'(1);
                if (slot_match)
                begin
                    res_next.slot_used = 2'(scan_reg);
                    if (req_reg.operation == OP_UNMOUNT)
                    begin
                        cnt_next            = CW'(slot_rd_data.first);
                        run_len_next        = slot_rd_data.count;
                        busy_next[scan_reg] = 1'b0;
                    end
                    else if (rx_sum_ok)
                    begin
                        res_next.global_index = HOST_BASE + rx_sum;
                    end
                    else
                    begin
                        res_next = '0;
                        res_next.status = STAT_UNAVAIL;
                    end
                end
                else
                begin
                    scan_next = scan_reg + SW'(1);
                    if (scan_last)
                    begin
                        res_next.status = STAT_UNAVAIL;
                    end
                end
            end
            S_FREE:
            begin
                owner_wr_en  = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                run_len_next = run_len_reg - COUNT_W'(1);
            end
            S_SEND_OWN:
            begin
                scan_next    = owner_rd_data[SW-1:0];
                slot_rd_addr = owner_rd_data[SW-1:0];
                if (!own_ok)
                begin
                    res_next.status = STAT_UNAVAIL;
                end
            end
            S_SEND_SLOT:
            begin
                if (send_cable < slot_rd_data.first)
                begin
                    res_next.status = STAT_UNAVAIL;
                end
                else
                begin
                    res_next.target_host_side = 1'b1;
                    res_next.target_interface = slot_rd_data.iface;
                    res_next.local_cable      = send_cable - slot_rd_data.first;
                    res_next.slot_used        = 2'(scan_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign req_ready = state_reg == S_IDLE;
    assign res_valid = state_reg == S_EMIT;
    assign res       = res_reg;

endmodule

### hw/rtl/cable_block_allocator_core.sv
// Cable block allocator core: top level with the output register and assertions.
// Depends on cba_pkg, cba_req_if, cba_rsp_if, cba_ctrl, cba_owner_mem, cba_slot_mem.
// One request is worked at a time; a finished response waits in the output register
// while the next request is taken. The ownership map is read one cable per cycle
// through its single read port. A mount scans for the first free run, then writes
// one owner entry per granted cable; an unmount scans the slot table, then writes
// one release per cable; a host-side receive scans the slot table; a host-side send
// reads the owner map, then the slot table; a device-side lookup reads neither.
// No clearing pass runs after reset.
module cable_block_allocator_core #(
    parameter int SLOTS  = cba_pkg::SLOTS_DEF,
    parameter int CABLES = cba_pkg::CABLES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    cba_req_if.sink          req,
    cba_rsp_if.source        rsp,
    input  logic             cfg_wr_en,
    input  logic [4:0]       cfg_wr_data
);
    import cba_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = (CABLES > 1) ? $clog2(CABLES) : 1;

    logic               res_valid;
    logic               res_ready;
    rsp_t               res;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_data_reg, rsp_data_next;

    logic               owner_wr_en;
    logic [CW-1:0]      owner_wr_addr;
    logic [OWNER_W-1:0] owner_wr_data;
    logic [CW-1:0]      owner_rd_addr;
    logic [OWNER_W-1:0] owner_rd_data;
    logic               slot_wr_en;
    logic [SW-1:0]      slot_wr_addr;
    slot_entry_t        slot_wr_data;
    logic [SW-1:0]      slot_rd_addr;
    slot_entry_t        slot_rd_data;

    cba_ctrl #(
        .SLOTS  (SLOTS),
        .CABLES (CABLES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req.valid),
        .req_ready     (req.ready),
        .req_payload   (req.payload),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .owner_wr_en   (owner_wr_en),
        .owner_wr_addr (owner_wr_addr),
        .owner_wr_data (owner_wr_data),
        .owner_rd_addr (owner_rd_addr),
        .owner_rd_data (owner_rd_data),
        .slot_wr_en    (slot_wr_en),
        .slot_wr_addr  (slot_wr_addr),
        .slot_wr_data  (slot_wr_data),
        .slot_rd_addr  (slot_rd_addr),
        .slot_rd_data  (slot_rd_data)
    );

    cba_owner_mem #(
        .CABLES (CABLES)
    ) u_owner_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (owner_wr_en),
        .wr_addr (owner_wr_addr),
        .wr_data (owner_wr_data),
        .rd_addr (owner_rd_addr),
        .rd_data (owner_rd_data)
    );

    cba_slot_mem #(
        .SLOTS (SLOTS)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data)
    );

    // hold the response until taken; reload in the same cycle it drains
    assign res_ready = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = res;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && res_valid))
        else $error("request taken while a result is pending in the sequencer");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("sequencer still idle after taking a request");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> rsp.valid && rsp.payload == $past(res))
        else $error("finished result not loaded into the output register");

    a_error_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.payload.status != STAT_OK |->
            rsp.payload.global_index == '0 && rsp.payload.target_host_side == 1'b0
            && rsp.payload.target_interface == '0 && rsp.payload.local_cable == '0
            && rsp.payload.slot_used == '0 && rsp.payload.block_start == '0
            && rsp.payload.block_size == '0)
        else $error("failed response carries nonzero fields");

endmodule

### tb/cable_block_allocator_core_tb.sv
// Self-checking testbench for cable_block_allocator_core: directed and random mount,
// unmount, send and receive lookups, each response checked against a local predictor.
// Depends on cba_pkg, cba_req_if, cba_rsp_if and the allocator RTL.
`timescale 1ns / 100ps

module cable_block_allocator_core_tb;
    import cba_pkg::*;

    localparam int SLOTS          = SLOTS_DEF;
    localparam int CABLES         = CABLES_DEF;
    localparam int SW             = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW             = (CABLES > 1) ? $clog2(CABLES) : 1;
    localparam int SETTLE_CYCLES  = 40;
    localparam int STALL_LIMIT    = 3000;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [4:0] cfg_wr_data;

    cba_req_if req_ch();
    cba_rsp_if rsp_ch();

    cable_block_allocator_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // predictor state
    logic [4:0]         dev_ports;
    logic               slot_taken [SLOTS];
    logic [7:0]         slot_id    [SLOTS];
    logic [3:0]         slot_base  [SLOTS];
    logic [COUNT_W-1:0] slot_len   [SLOTS];
    logic [OWNER_W-1:0] owner_map  [CABLES];

    rsp_t awaited_rsp_q [$];
    int   error_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   quiet_cycles;

    always #2 clk = ~clk;

    function automatic rsp_t allocate_or_lookup(input req_t r);
        rsp_t               o;
        int                 need;
        int                 s;
        int                 c;
        int                 k;
        int                 sum;
        bit                 fits;
        bit                 hit;
        logic [3:0]         cab;
        logic [OWNER_W-1:0] own;
        o = '0;
        o.status = STAT_OK;
        case (r.operation)
            OP_MOUNT:
            begin
                need = (r.rx_cables > r.tx_cables) ? int'(r.rx_cables) : int'(r.tx_cables);
                if (need < 1)
                    need = 1;
                s = SLOTS;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!slot_taken[SW'(i)])
                        s = i;
                if (s == SLOTS)
                    o.status = STAT_NO_SLOT;
                else
                begin
                    o.status = STAT_NO_ROOM;
                    for (c = 0; c + need <= CABLES && o.status != STAT_OK; c++)
                    begin
                        fits = 1'b1;
                        for (k = 0; k < need; k++)
                            if (owner_map[CW'(c + k)] != UNOWNED)
                                fits = 1'b0;
                        if (fits)
                        begin
                            for (k = 0; k < need; k++)
                                owner_map[CW'(c + k)] = OWNER_W'(s);
                            slot_taken[SW'(s)] = 1'b1;
                            slot_id[SW'(s)]    = r.interface_id;
                            slot_base[SW'(s)]  = 4'(c);
                            slot_len[SW'(s)]   = COUNT_W'(need);
                            o.status           = STAT_OK;
                            o.slot_used        = 2'(s);
                            o.block_start      = 4'(c);
                            o.block_size       = 5'(need);
                        end
                    end
                end
            end
            OP_UNMOUNT:
            begin
                o.status = STAT_UNAVAIL;
                for (s = 0; s < SLOTS; s++)
                begin
                    if (o.status != STAT_OK && slot_taken[SW'(s)]
                        && slot_id[SW'(s)] == r.interface_id)
                    begin
                        for (k = 0; k < int'(slot_len[SW'(s)]); k++)
                            if (int'(slot_base[SW'(s)]) + k < CABLES)
                                owner_map[CW'(int'(slot_base[SW'(s)]) + k)] = UNOWNED;
                        slot_taken[SW'(s)] = 1'b0;
                        o.status           = STAT_OK;
                        o.slot_used        = 2'(s);
                    end
                end
            end
            OP_SEND:
            begin
                cab = r.port_index[3:0];
                if (!r.port_index[4])
                begin
                    if ({1'b0, cab} < dev_ports && r.device_mounted)
                        o.local_cable = cab;
                    else
                        o.status = STAT_UNAVAIL;
                end
                else
                begin
                    own = owner_map[CW'(cab)];
                    if (own >= OWNER_W'(SLOTS) || !slot_taken[own[SW-1:0]]
                        || !r.interface_mounted || cab < slot_base[own[SW-1:0]])
                        o.status = STAT_UNAVAIL;
                    else
                    begin
                        o.target_host_side = 1'b1;
                        o.target_interface = slot_id[own[SW-1:0]];
                        o.local_cable      = cab - slot_base[own[SW-1:0]];
                        o.slot_used        = 2'(own);
                    end
                end
            end
            default:
            begin
                if (r.from_device_side)
                begin
                    if (r.device_mounted)
                        o.global_index = {1'b0, r.packet_cable};
                    else
                        o.status = STAT_UNAVAIL;
                end
                else
                begin
                    o.status = STAT_UNAVAIL;
                    hit = 1'b0;
                    for (s = 0; s < SLOTS; s++)
                    begin
                        if (!hit && slot_taken[SW'(s)] && slot_id[SW'(s)] == r.interface_id)
                        begin
                            hit = 1'b1;
                            sum = int'(slot_base[SW'(s)]) + int'(r.packet_cable);
                            if (sum < CABLES)
                            begin
                                o.status       = STAT_OK;
                                o.global_index = HOST_BASE + 5'(sum);
                                o.slot_used    = 2'(s);
                            end
                        end
                    end
                end
            end
        endcase
        return o;
    endfunction

    function automatic req_t build_request(input op_t op, input logic [4:0] port,
                                           input logic [7:0] iface, input logic [4:0] rx,
                                           input logic [4:0] tx, input logic side,
                                           input logic [3:0] pc, input logic dm,
                                           input logic im);
        req_t r;
        r.operation         = op;
        r.port_index        = port;
        r.interface_id      = iface;
        r.rx_cables         = rx;
        r.tx_cables         = tx;
        r.from_device_side  = side;
        r.packet_cable      = pc;
        r.device_mounted    = dm;
        r.interface_mounted = im;
        return r;
    endfunction

    function automatic logic [7:0] pick_interface();
        int s;
        s = int'($urandom_range(SLOTS - 1));
        if ($urandom_range(9) < 6 && slot_taken[SW'(s)])
            return slot_id[SW'(s)];
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'h7f;
            3: return 8'h80;
            4: return 8'hff;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic req_t next_traffic_request();
        req_t r;
        int   pick;
        r = req_t'($urandom);
        if ($urandom_range(99) < 15)
            return r;
        r.device_mounted    = ($urandom_range(9) != 0);
        r.interface_mounted = ($urandom_range(9) != 0);
        pick = int'($urandom_range(99));
        if (pick < 25)
        begin
            r.operation    = OP_MOUNT;
            r.interface_id = pick_interface();
            if ($urandom_range(9) == 0)
            begin
                r.rx_cables = 5'($urandom_range(16));
                r.tx_cables = 5'($urandom_range(16));
            end
            else
            begin
                r.rx_cables = 5'($urandom_range(4));
                r.tx_cables = 5'($urandom_range(4));
            end
        end
        else if (pick < 45)
        begin
            r.operation    = OP_UNMOUNT;
            r.interface_id = pick_interface();
        end
        else if (pick < 75)
        begin
            r.operation  = OP_SEND;
            r.port_index = {($urandom_range(9) < 7), 4'($urandom_range(15))};
        end
        else
        begin
            r.operation        = OP_RECEIVE;
            r.from_device_side = ($urandom_range(9) < 3);
            r.interface_id     = pick_interface();
            r.packet_cable     = 4'(($urandom_range(3) == 0) ? $urandom_range(15)
                                                              : $urandom_range(3));
        end
        return r;
    endfunction

    task automatic send_request(input req_t r);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        forever
        begin
            @(posedge clk);
            if (req_ch.ready)
                break;
        end
        awaited_rsp_q.push_back(allocate_or_lookup(r));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (awaited_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_device_ports(input logic [4:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        dev_ports    = value;
    endtask

    task automatic test_directed_cases();
        send_request(build_request(OP_SEND, 5'd0, 8'h00, 0, 0, 0, 0, 1, 1));
        send_request(build_request(OP_SEND, 5'd15, 8'h00, 0, 0, 0, 0, 1, 1));
        send_request(build_request(OP_SEND, 5'd0, 8'h00, 0, 0, 0, 0, 0, 1));
        send_request(build_request(OP_RECEIVE, 5'd0, 8'h00, 0, 0, 1, 4'd15, 1, 0));
        send_request(build_request(OP_RECEIVE, 5'd0, 8'h00, 0, 0, 1, 4'd3, 0, 0));
        send_request(build_request(OP_RECEIVE, 5'd0, 8'h05, 0, 0, 0, 4'd0, 1, 1));
        send_request(build_request(OP_UNMOUNT, 5'd0, 8'h05, 0, 0, 0, 0, 1, 1));
        send_request(build_request(OP_MOUNT, 5'd0, 8'hff, 5'd0, 5'd0, 0, 0, 1, 1));
        send_request(build_request(OP_MOUNT, 5'd0, 8'h00, 5'd3, 5'd2, 0, 0, 1, 1));
        send_request(build_request(OP_MOUNT, 5'd0, 8'h00, 5'd1, 5'd5, 0, 0, 1, 1));
        send_request(build_request(OP_MOUNT, 5'd0, 8'haa, 5'd17, 5'd0, 0, 0, 1, 1));
        send_request(build_request(OP_MOUNT, 5'd0, 8'h55, 5'd31, 5'd31, 0, 0, 1, 1));
        send_request(build_request(OP_MOUNT, 5'd0, 8'h55, 5'd8, 5'd7, 0, 0, 1, 1));
        send_request(build_request(OP_MOUNT, 5'd0, 8'h55, 5'd7, 5'd0, 0, 0, 1, 1));
        send_request(build_request(OP_MOUNT, 5'd0, 8'h01, 5'd1, 5'd1, 0, 0, 1, 1));
        send_request(build_request(OP_SEND, 5'd21, 8'h00, 0, 0, 0, 0, 1, 1));
        send_request(build_request(OP_SEND, 5'd31, 8'h00, 0, 0, 0, 0, 1, 0));
        send_request(build_request(OP_RECEIVE, 5'd0, 8'h00, 0, 0, 0, 4'd2, 1, 1));
        send_request(build_request(OP_RECEIVE, 5'd0, 8'h55, 0, 0, 0, 4'd7, 1, 1));
        send_request(build_request(OP_UNMOUNT, 5'd0, 8'h00, 0, 0, 0, 0, 1, 1));
        send_request(build_request(OP_SEND, 5'd17, 8'h00, 0, 0, 0, 0, 1, 1));
        send_request(build_request(OP_RECEIVE, 5'd0, 8'h00, 0, 0, 0, 4'd15, 1, 1));
        send_request(build_request(OP_UNMOUNT, 5'd0, 8'hff, 0, 0, 0, 0, 1, 1));
        send_request(build_request(OP_UNMOUNT, 5'd0, 8'h00, 0, 0, 0, 0, 1, 1));
        send_request(build_request(OP_UNMOUNT, 5'd0, 8'h55, 0, 0, 0, 0, 1, 1));
        send_request(build_request(OP_MOUNT, 5'd0, 8'h3c, 5'd16, 5'd16, 0, 0, 1, 1));
        send_request(build_request(OP_SEND, 5'd31, 8'h00, 0, 0, 0, 0, 1, 1));
        send_request(build_request(OP_UNMOUNT, 5'd0, 8'h3c, 0, 0, 0, 0, 1, 1));
    endtask

    task automatic test_device_port_setting();
        write_device_ports(5'd16);
        send_request(build_request(OP_SEND, 5'd15, 8'h00, 0, 0, 0, 0, 1, 0));
        send_request(build_request(OP_SEND, 5'd0, 8'h00, 0, 0, 0, 0, 1, 0));
        write_device_ports(5'd9);
        send_request(build_request(OP_SEND, 5'd8, 8'h00, 0, 0, 0, 0, 1, 0));
        send_request(build_request(OP_SEND, 5'd9, 8'h00, 0, 0, 0, 0, 1, 0));
        write_device_ports(5'd1);
        send_request(build_request(OP_SEND, 5'd1, 8'h00, 0, 0, 0, 0, 1, 0));
        send_request(build_request(OP_SEND, 5'd0, 8'h00, 0, 0, 0, 0, 1, 0));
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct, input logic [4:0] ports);
        write_device_ports(ports);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            send_request(next_traffic_request());
            // after every 50th request, hold off until every response is back
            if (n % 50 == 49)
                wait_drained();
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        rsp_t want;
        rsp_t got;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.payload;
            if (awaited_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected response: expected none, actual %p", $time, got);
                error_count++;
            end
            else
            begin
                want = awaited_rsp_q.pop_front();
                compare_field("status", 8'(want.status), 8'(got.status));
                compare_field("global_index", 8'(want.global_index), 8'(got.global_index));
                compare_field("target_host_side", 8'(want.target_host_side),
                              8'(got.target_host_side));
                compare_field("target_interface", want.target_interface,
                              got.target_interface);
                compare_field("local_cable", 8'(want.local_cable), 8'(got.local_cable));
                compare_field("slot_used", 8'(want.slot_used), 8'(got.slot_used));
                compare_field("block_start", 8'(want.block_start), 8'(got.block_start));
                compare_field("block_size", 8'(want.block_size), 8'(got.block_size));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("cable_block_allocator_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        quiet_cycles   = 0;
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        dev_ports      = 5'd1;
        for (int s = 0; s < SLOTS; s++)
        begin
            slot_taken[SW'(s)] = 1'b0;
            slot_id[SW'(s)]    = '0;
            slot_base[SW'(s)]  = '0;
            slot_len[SW'(s)]   = '0;
        end
        for (int c = 0; c < CABLES; c++)
            owner_map[CW'(c)] = UNOWNED;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_device_port_setting();
        test_random_traffic(150, 0, 0, 5'd16);
        test_random_traffic(150, 73, 0, 5'($urandom_range(2, 15)));
        test_random_traffic(150, 0, 73, 5'd1);
        test_random_traffic(150, 8, 8, 5'd16);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("cable_block_allocator_core regression: pass");
        else
            $display("cable_block_allocator_core regression: fail");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/cba_pkg.sv
hw/rtl/cba_req_if.sv
hw/rtl/cba_rsp_if.sv
hw/rtl/cba_owner_mem.sv
hw/rtl/cba_slot_mem.sv
hw/rtl/cba_ctrl.sv
hw/rtl/cable_block_allocator_core.sv
tb/cable_block_allocator_core_tb.sv
